// File: design/dtof_pkg.sv
package dtof_pkg;

  // Default timestamp width and the fixed widths of the item fields.
  localparam int STAMP_BITS_DEF = 32;
  localparam int IN_W           = 32;
  localparam int SPAN_W         = 32;
  localparam int FLIGHT_W       = 33;

  // Largest flight time magnitude that the result field carries.
  localparam logic [31:0] FLIGHT_CAP = 32'hFFFF_FFFF;

  // Seven timestamps of one ranging exchange.
  typedef struct packed {
    logic [IN_W-1:0] poll_sent_time;
    logic [IN_W-1:0] reply_heard_time;
    logic [IN_W-1:0] final_sent_time;
    logic [IN_W-1:0] report_heard_time;
    logic [IN_W-1:0] remote_poll_heard;
    logic [IN_W-1:0] remote_reply_sent;
    logic [IN_W-1:0] remote_final_heard;
  } stamps_t;

  // One ranging result.
  typedef struct packed {
    logic signed [FLIGHT_W-1:0] flight_time;
    logic [SPAN_W-1:0]          exchange_span;
    logic                       zero_divisor;
  } result_t;

endpackage

// File: design/ds_twr_time_of_flight_unit.sv
// Double-sided two-way ranging solver. Give it the seven timestamps of one
// exchange with start while busy is low; busy is high during reset and in the
// cycle after it. The unit takes a new item in every cycle in which busy is
// low. Each result comes out with done, which is high for a single cycle. The
// receiver must take the result then, as results cannot be held off. The
// restoring divider resolves one quotient bit per pipeline stage. Five more
// stages hold the interval differences, the split multipliers, the product
// assembly, the numerator subtract and the output saturation and sign.
// A zero interval sum gives a zero flight time with zero_divisor set;
// exchange_span is valid in every result.
module ds_twr_time_of_flight_unit
  import dtof_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  stamps_t stamps,
  output logic    done,
  output result_t result
);

  localparam int W     = STAMP_BITS;
  localparam int LO_W  = (W + 1) / 2;
  localparam int HI_W  = W - LO_W;
  localparam int DEN_W = W + 2;
  localparam int EXT_W = (W > SPAN_W) ? W : SPAN_W;

  // Input reduction to the timestamp width.
  logic [W-1:0] poll_tx, resp_rx, final_tx, report_rx;
  logic [W-1:0] r_poll_rx, r_resp_tx, r_final_rx;

  assign poll_tx    = W'(stamps.poll_sent_time);
  assign resp_rx    = W'(stamps.reply_heard_time);
  assign final_tx   = W'(stamps.final_sent_time);
  assign report_rx  = W'(stamps.report_heard_time);
  assign r_poll_rx  = W'(stamps.remote_poll_heard);
  assign r_resp_tx  = W'(stamps.remote_reply_sent);
  assign r_final_rx = W'(stamps.remote_final_heard);

  // The unit is ready except during reset and just after it.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Stage 1: wrapping round and reply intervals and the exchange span.
  logic         s1_valid;
  logic [W-1:0] s1_ra, s1_rb, s1_da, s1_db, s1_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_ra   <= resp_rx - poll_tx;
    s1_rb   <= r_final_rx - r_resp_tx;
    s1_da   <= final_tx - resp_rx;
    s1_db   <= r_resp_tx - r_poll_rx;
    s1_span <= report_rx - poll_tx;
  end

  // Stage 2: partial products of both multiplications and the interval sum.
  logic              s2_valid;
  logic [2*LO_W-1:0] s2_p_ll, s2_q_ll;
  logic [W-1:0]      s2_p_lh, s2_p_hl, s2_q_lh, s2_q_hl;
  logic [2*HI_W-1:0] s2_p_hh, s2_q_hh;
  logic [DEN_W-1:0]  s2_den;
  logic [W-1:0]      s2_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_p_ll <= s1_ra[LO_W-1:0] * s1_rb[LO_W-1:0];
    s2_p_lh <= s1_ra[LO_W-1:0] * s1_rb[W-1:LO_W];
    s2_p_hl <= s1_ra[W-1:LO_W] * s1_rb[LO_W-1:0];
    s2_p_hh <= s1_ra[W-1:LO_W] * s1_rb[W-1:LO_W];
    s2_q_ll <= s1_da[LO_W-1:0] * s1_db[LO_W-1:0];
    s2_q_lh <= s1_da[LO_W-1:0] * s1_db[W-1:LO_W];
    s2_q_hl <= s1_da[W-1:LO_W] * s1_db[LO_W-1:0];
    s2_q_hh <= s1_da[W-1:LO_W] * s1_db[W-1:LO_W];
    s2_den  <= DEN_W'(s1_ra) + DEN_W'(s1_rb) + DEN_W'(s1_da) + DEN_W'(s1_db);
    s2_span <= s1_span;
  end

  // Stage 3: full products Ra*Rb and Da*Db.
  logic             s3_valid;
  logic [2*W-1:0]   s3_p, s3_q;
  logic [DEN_W-1:0] s3_den;
  logic [W-1:0]     s3_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_p <= (2*W)'(s2_p_ll)
          + ((2*W)'(s2_p_lh) << LO_W) + ((2*W)'(s2_p_hl) << LO_W)
          + ((2*W)'(s2_p_hh) << (2*LO_W));
    s3_q <= (2*W)'(s2_q_ll)
          + ((2*W)'(s2_q_lh) << LO_W) + ((2*W)'(s2_q_hl) << LO_W)
          + ((2*W)'(s2_q_hh) << (2*LO_W));
    s3_den  <= s2_den;
    s3_span <= s2_span;
  end

  // Divider pipeline. Entry 0 holds the numerator magnitude split into a
  // partial remainder (its upper half) and the low half, which shifts out
  // one bit per stage while quotient bits shift in behind it. The quotient
  // always fits in W bits since Ra*Rb/(Ra+Rb) stays below min(Ra, Rb).
  logic             div_valid [0:W];
  logic [DEN_W-1:0] div_rem   [0:W];
  logic [W-1:0]     div_low   [0:W];
  logic [DEN_W-1:0] div_den   [0:W];
  logic             div_neg   [0:W];
  logic             div_zero  [0:W];
  logic [W-1:0]     div_span  [0:W];

  // Stage 4: sign and magnitude of the numerator, divisor check.
  logic           num_neg;
  logic [2*W-1:0] num_mag;

  always_comb begin
    num_neg = s3_p < s3_q;
    num_mag = num_neg ? (s3_q - s3_p) : (s3_p - s3_q);
  end

  // One restoring division step per stage.
  logic [DEN_W:0]   trial    [0:W-1];
  logic             qbit     [0:W-1];
  logic [DEN_W-1:0] rem_next [0:W-1];
  logic [W-1:0]     low_next [0:W-1];

  always_comb begin
    for (int k = 0; k < W; k++) begin
      trial[k] = {div_rem[k], div_low[k][W-1]};
      qbit[k]  = trial[k] >= {1'b0, div_den[k]};
      if (qbit[k]) begin
        rem_next[k] = DEN_W'(trial[k] - {1'b0, div_den[k]});
      end else begin
        rem_next[k] = DEN_W'(trial[k]);
      end
      low_next[k] = {div_low[k][W-2:0], qbit[k]};
    end
  end

  // Divider registers: stage 4 loads entry 0, each later entry takes one step.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else begin
      div_valid[0] <= s3_valid;
    end
    div_rem[0]  <= DEN_W'(num_mag[2*W-1:W]);
    div_low[0]  <= num_mag[W-1:0];
    div_den[0]  <= s3_den;
    div_neg[0]  <= num_neg;
    div_zero[0] <= s3_den == '0;
    div_span[0] <= s3_span;
    for (int k = 0; k < W; k++) begin
      if (rst) begin
        div_valid[k+1] <= 1'b0;
      end else begin
        div_valid[k+1] <= div_valid[k];
      end
      div_rem[k+1]  <= rem_next[k];
      div_low[k+1]  <= low_next[k];
      div_den[k+1]  <= div_den[k];
      div_neg[k+1]  <= div_neg[k];
      div_zero[k+1] <= div_zero[k];
      div_span[k+1] <= div_span[k];
    end
  end

  // Output stage: saturate, restore the sign, apply the zero divisor case.
  logic [EXT_W-1:0]    quo_ext;
  logic [EXT_W-1:0]    span_ext;
  logic [31:0]         quo_mag;
  logic [FLIGHT_W-1:0] flight;

  always_comb begin
    quo_ext  = EXT_W'(div_low[W]);
    span_ext = EXT_W'(div_span[W]);
    if ((quo_ext >> 32) != '0) begin
      quo_mag = FLIGHT_CAP;
    end else begin
      quo_mag = quo_ext[31:0];
    end
    if (div_zero[W]) begin
      flight = '0;
    end else if (div_neg[W]) begin
      flight = -{1'b0, quo_mag};
    end else begin
      flight = {1'b0, quo_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid[W];
    end
    result.flight_time   <= flight;
    result.exchange_span <= span_ext[SPAN_W-1:0];
    result.zero_divisor  <= div_zero[W];
  end

endmodule
